/* rtl/sud_pkg.sv */
package sud_pkg;

    // input operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_CLEAR = 2'd0;
    localparam t_op OP_LOAD  = 2'd1;
    localparam t_op OP_PROBE = 2'd2;

    // set_mode register codes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_UNION = 2'd0;
    localparam t_mode MODE_DIFF  = 2'd1;
    localparam t_mode MODE_INTER = 2'd2;

    localparam int VALUE_W = 32;

    // result beat handed from the controller to the output register
    typedef struct packed {
        logic signed [VALUE_W-1:0] echo_value;
        logic                      kept;
        logic                      overflow;
    } t_result;

endpackage

/* rtl/sud_mem.sv */
module sud_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int W     = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sud_ctrl.sv */
module sud_ctrl #(
    parameter int SET_DEPTH = 16,
    parameter int AW        = 4,
    parameter int CW        = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sud_pkg::t_mode               i_mode,
    // input beat
    input  logic                         i_valid,
    output logic                         o_stall,
    input  sud_pkg::t_op                 i_operation,
    input  logic signed [31:0]           i_value,
    // result beat towards the output register
    output logic                         o_res_valid,
    input  logic                         i_res_free,
    output sud_pkg::t_result             o_res,
    // table memory
    output logic                         o_we,
    output logic [AW-1:0]                o_waddr,
    output logic [31:0]                  o_wdata,
    output logic                         o_re,
    output logic [AW-1:0]                o_raddr,
    input  logic [31:0]                  i_rdata
);

    import sud_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state             r_state;
    t_op                r_op;
    logic signed [31:0] r_val;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic               r_rd_vld;
    logic               r_present;

    logic               full;
    logic               last_rd;
    logic               hit;
    logic               accept;
    logic               finish;
    logic               n_kept;
    logic               n_ovf;
    logic               n_append;

    assign full    = (r_count == CW'(SET_DEPTH));
    assign last_rd = (r_idx == r_count - CW'(1));
    assign hit     = r_rd_vld && (i_rdata == r_val);
    assign accept  = (r_state == S_IDLE) && i_valid;
    assign finish  = (r_state == S_FIN) && i_res_free;

    assign o_stall = (r_state != S_IDLE);

    // result and append decision once the scan is over
    always_comb begin
        n_kept   = 1'b0;
        n_ovf    = 1'b0;
        n_append = 1'b0;
        case (r_op)
            OP_LOAD: begin
                if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_kept   = 1'b1;
                    n_append = 1'b1;
                end
            end
            OP_PROBE: begin
                unique case (i_mode)
                    MODE_UNION: begin
                        if (!r_present) begin
                            n_kept = 1'b1;
                            if (full) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_append = 1'b1;
                            end
                        end
                    end
                    MODE_DIFF:  n_kept = !r_present;
                    MODE_INTER: n_kept = r_present;
                    default:    n_kept = 1'b0;
                endcase
            end
            default: begin
                n_kept = 1'b0;
            end
        endcase
    end

    // memory access
    assign o_re    = (r_state == S_SCAN);
    assign o_raddr = r_idx[AW-1:0];
    assign o_we    = finish && n_append;
    assign o_waddr = r_count[AW-1:0];
    assign o_wdata = r_val;

    assign o_res_valid     = finish;
    assign o_res.echo_value = r_val;
    assign o_res.kept       = n_kept;
    assign o_res.overflow   = n_ovf;

    // sequencer: accept, scan the table one entry a cycle on a probe of a non-empty table, drain, finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_present <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SCAN);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op      <= i_operation;
                        r_val     <= i_value;
                        r_idx     <= '0;
                        r_present <= 1'b0;
                        if (i_operation == OP_PROBE && r_count != '0) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_present <= 1'b1;
                    end
                    r_idx <= r_idx + CW'(1);
                    if (last_rd) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (hit) begin
                        r_present <= 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (finish) begin
                        if (r_op == OP_CLEAR) begin
                            r_count <= '0;
                        end else if (n_append) begin
                            r_count <= r_count + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/set_union_difference_intersection.sv */
// channel   direction  handshake              payload
// input     in         i_valid / o_stall      i_operation, i_value
// result    out        o_valid / i_stall      o_echo_value, o_kept, o_overflow
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_set_mode
//
// clear, load, other operations and a probe of an empty table go straight to the finish; a probe
// of a non-empty table first scans every entry of the table memory, one read a cycle through
// its single read port, which is registered.
// synchronous active-low reset empties the table and sets mode to union.
// a stalled result sits in the output register while the next item is taken.
module set_union_difference_intersection #(
    parameter int SET_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sud_pkg::t_op       i_operation,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_echo_value,
    output logic               o_kept,
    output logic               o_overflow,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  sud_pkg::t_mode     i_cfg_set_mode
);

    import sud_pkg::*;

    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CW = $clog2(SET_DEPTH + 1);

    t_mode    r_mode;
    logic     r_out_valid;
    t_result  r_out;

    logic     res_valid;
    logic     res_free;
    t_result  res;

    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [31:0]   rdata;

    // mode register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_UNION;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_set_mode;
        end
    end

    sud_ctrl #(
        .SET_DEPTH(SET_DEPTH),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_operation(i_operation),
        .i_value    (i_value),
        .o_res_valid(res_valid),
        .i_res_free (res_free),
        .o_res      (res),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    sud_mem #(
        .DEPTH(SET_DEPTH),
        .AW   (AW),
        .W    (32)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // output register
    assign res_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_echo_value = r_out.echo_value;
    assign o_kept       = r_out.kept;
    assign o_overflow   = r_out.overflow;

endmodule

/* verif/set_union_difference_intersection_tb.sv */
module set_union_difference_intersection_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sud_pkg::*;

    localparam int    SET_DEPTH    = 16;
    localparam int    CLK_PERIOD   = 4;
    localparam int    LIMIT_CYCLES = 1_000_000;
    localparam int    HOLD_CYCLES  = 400;
    localparam int    PHASE_ITEMS  = 190;
    localparam int    NUM_PHASES   = 8;
    localparam int    MAX_PRINTS   = 40;
    localparam t_op   OP_SPARE     = 2'd3;
    localparam t_mode MODE_SPARE   = 2'd3;

    // one row of the directed table; typed rows carry their own expected flags
    typedef struct {
        t_mode       mode;
        t_op         op;
        logic [31:0] val;
        int          reps;
        bit          typed;
        bit          kept;
        bit          overflow;
    } t_row;

    typedef struct packed {
        bit typed;
        bit kept;
        bit overflow;
    } t_typed;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_stall;
    t_op                i_operation    = OP_CLEAR;
    logic signed [31:0] i_value        = '0;
    logic               o_valid;
    logic               i_stall        = 1'b0;
    logic signed [31:0] o_echo_value;
    logic               o_kept;
    logic               o_overflow;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    t_mode              i_cfg_set_mode = MODE_UNION;

    // membership model state
    logic [31:0] model_entries [SET_DEPTH];
    int unsigned model_count;
    t_mode       model_mode;

    t_result pending_results [$];
    t_typed  typed_results [$];

    t_mode cur_mode   = MODE_UNION;
    bit    no_idle    = 1'b0;
    bit    hold_req   = 1'b0;
    int    cycle_count;
    int    items_sent;
    int    results_seen;
    int    error_count;
    int    mode_writes;
    int    holds_done;
    int    op_tally [4];
    int    kept_tally;
    int    overflow_tally;

    t_mode phase_modes [NUM_PHASES] = '{MODE_UNION, MODE_DIFF, MODE_INTER, MODE_UNION,
                                        MODE_SPARE, MODE_INTER, MODE_DIFF, MODE_UNION};

    t_row dir_rows [20] = '{
        '{MODE_UNION, OP_PROBE, 32'h0000_0005, 1,  1'b1, 1'b1, 1'b0},
        '{MODE_UNION, OP_PROBE, 32'h0000_0005, 1,  1'b1, 1'b0, 1'b0},
        '{MODE_UNION, OP_LOAD,  32'h7fff_ffff, 1,  1'b1, 1'b1, 1'b0},
        '{MODE_UNION, OP_LOAD,  32'h8000_0000, 1,  1'b1, 1'b1, 1'b0},
        '{MODE_UNION, OP_PROBE, 32'h8000_0000, 1,  1'b0, 1'b0, 1'b0},
        '{MODE_UNION, OP_PROBE, 32'hffff_ffff, 1,  1'b0, 1'b0, 1'b0},
        '{MODE_UNION, OP_SPARE, 32'hffff_ffff, 1,  1'b1, 1'b0, 1'b0},
        '{MODE_UNION, OP_CLEAR, 32'ha5a5_a5a5, 1,  1'b1, 1'b0, 1'b0},
        '{MODE_UNION, OP_LOAD,  32'h0000_1000, 16, 1'b1, 1'b1, 1'b0},
        '{MODE_UNION, OP_LOAD,  32'h5a5a_5a5a, 1,  1'b1, 1'b0, 1'b1},
        '{MODE_UNION, OP_PROBE, 32'h0000_0000, 1,  1'b1, 1'b1, 1'b1},
        '{MODE_UNION, OP_PROBE, 32'h0000_100f, 1,  1'b0, 1'b0, 1'b0},
        '{MODE_DIFF,  OP_PROBE, 32'h0000_1003, 1,  1'b0, 1'b0, 1'b0},
        '{MODE_DIFF,  OP_PROBE, 32'h1234_5678, 1,  1'b0, 1'b0, 1'b0},
        '{MODE_INTER, OP_PROBE, 32'h0000_1003, 1,  1'b0, 1'b0, 1'b0},
        '{MODE_INTER, OP_PROBE, 32'h1234_5678, 1,  1'b0, 1'b0, 1'b0},
        '{MODE_INTER, OP_LOAD,  32'h0000_0001, 1,  1'b1, 1'b0, 1'b1},
        '{MODE_SPARE, OP_PROBE, 32'h0000_1000, 1,  1'b1, 1'b0, 1'b0},
        '{MODE_SPARE, OP_CLEAR, 32'h0000_0000, 1,  1'b1, 1'b0, 1'b0},
        '{MODE_SPARE, OP_PROBE, 32'h0000_0007, 1,  1'b1, 1'b0, 1'b0}
    };

    set_union_difference_intersection #(
        .SET_DEPTH(SET_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_echo_value   (o_echo_value),
        .o_kept         (o_kept),
        .o_overflow     (o_overflow),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_set_mode (i_cfg_set_mode)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // work out the result of one input beat and update the model table
    function automatic t_result predict_membership(t_op op, logic [31:0] v);
        t_result r;
        bit      present;
        r.echo_value = v;
        r.kept       = 1'b0;
        r.overflow   = 1'b0;
        present      = 1'b0;
        case (op)
            OP_CLEAR: begin
                model_count = 0;
            end
            OP_LOAD: begin
                if (model_count < SET_DEPTH) begin
                    model_entries[model_count] = v;
                    model_count++;
                    r.kept = 1'b1;
                end else begin
                    r.overflow = 1'b1;
                end
            end
            OP_PROBE: begin
                for (int i = 0; i < model_count; i++) begin
                    if (model_entries[i] == v) present = 1'b1;
                end
                case (model_mode)
                    MODE_UNION: begin
                        if (!present) begin
                            r.kept = 1'b1;
                            if (model_count < SET_DEPTH) begin
                                model_entries[model_count] = v;
                                model_count++;
                            end else begin
                                r.overflow = 1'b1;
                            end
                        end
                    end
                    MODE_DIFF:  r.kept = !present;
                    MODE_INTER: r.kept = present;
                    default:    ;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
        if (error_count < MAX_PRINTS) begin
            $display("mismatch on %s at result %0d: got %0h, expected %0h",
                     field, results_seen, got, want);
        end
        error_count++;
    endtask

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // values cluster around a base so probes hit loaded entries
    function automatic logic [31:0] pick_value(logic [31:0] base);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return base + $urandom_range(0, 11);
        endcase
    endfunction

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // config and input beats feed the model
    always @(posedge i_clk) begin
        t_result r;
        t_typed  tv;
        if (!i_rst_n) begin
            model_count = 0;
            model_mode  = MODE_UNION;
        end else begin
            if (i_cfg_valid && o_cfg_ready) model_mode = i_cfg_set_mode;
            if (i_valid && !o_stall) begin
                r  = predict_membership(i_operation, i_value);
                tv = '0;
                if (typed_results.size() != 0) tv = typed_results.pop_front();
                if (tv.typed) begin
                    r.kept     = tv.kept;
                    r.overflow = tv.overflow;
                end
                pending_results.push_back(r);
                op_tally[i_operation]++;
            end
        end
    end

    // result beats against the oldest expectation
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected beat", o_echo_value, '0);
            end else begin
                e = pending_results.pop_front();
                if (o_echo_value !== e.echo_value)
                    flag_mismatch("echo_value", o_echo_value, e.echo_value);
                if (o_kept !== e.kept)
                    flag_mismatch("kept", 32'(o_kept), 32'(e.kept));
                if (o_overflow !== e.overflow)
                    flag_mismatch("overflow", 32'(o_overflow), 32'(e.overflow));
            end
            if (o_kept === 1'b1) kept_tally++;
            if (o_overflow === 1'b1) overflow_tally++;
            results_seen++;
        end
    end

    // receiver stall, with one long hold-off on request
    initial begin
        int n;
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end else begin
                n = no_idle ? 0 : idle_len();
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(t_op op, logic [31:0] v, t_typed tv);
        int n;
        typed_results.push_back(tv);
        i_valid     <= 1'b1;
        i_operation <= op;
        i_value     <= v;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        n = no_idle ? 0 : idle_len();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // occasionally swap in any operation code as noise
    task automatic send_random(t_op op, logic [31:0] base);
        t_op use_op;
        use_op = op;
        if ($urandom_range(0, 11) == 0) use_op = t_op'($urandom_range(0, 3));
        send_item(use_op, pick_value(base), '0);
    endtask

    // wait for all results, then write the mode register
    task automatic write_mode(t_mode m);
        i_valid <= 1'b0;
        while (results_seen != items_sent) @(posedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_set_mode <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_mode = m;
        mode_writes++;
    endtask

    // optionally clear, then fill and probe the set
    task automatic run_sequence();
        logic [31:0] base;
        int          n_loads;
        int          n_probes;
        base = $urandom;
        if ($urandom_range(0, 3) != 0) send_random(OP_CLEAR, base);
        n_loads = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 8);
        repeat (n_loads) send_random(OP_LOAD, base);
        n_probes = $urandom_range(1, 20);
        repeat (n_probes) send_random(OP_PROBE, base);
    endtask

    // main stimulus
    initial begin
        t_typed tv;
        int     stop_at;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[k]) begin
            if (dir_rows[k].mode != cur_mode) write_mode(dir_rows[k].mode);
            for (int j = 0; j < dir_rows[k].reps; j++) begin
                tv = '{dir_rows[k].typed, dir_rows[k].kept, dir_rows[k].overflow};
                send_item(dir_rows[k].op, dir_rows[k].val + j, tv);
            end
        end

        // random phases, one mode setting each
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_mode(phase_modes[p]);
            no_idle = (p % 4 == 1);
            if (p == 3) hold_req = 1'b1;
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at) run_sequence();
        end

        // drain
        i_valid <= 1'b0;
        while (results_seen != items_sent) @(posedge i_clk);
        repeat (SET_DEPTH + 8) @(posedge i_clk);

        $display("covered %0d beats: %0d clear, %0d load, %0d probe, %0d unused op, %0d mode writes",
                 items_sent, op_tally[OP_CLEAR], op_tally[OP_LOAD], op_tally[OP_PROBE],
                 op_tally[OP_SPARE], mode_writes);
        $display("%0d results kept, %0d with overflow, %0d long receiver hold-off, %0d mismatches",
                 kept_tally, overflow_tally, holds_done, error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
